[hdl/zobtt_pkg.sv]
package zobtt_pkg;

	localparam int BOARD_W    = 64;
	localparam int KEY_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int VALUE_W    = 4;
	localparam int SLOT_W     = 16;
	localparam int MATCH_W    = 53;
	localparam int VALUE_LSB  = 60;
	localparam int CODE_W     = 4;
	localparam int CELL_COUNT = 12;
	localparam int PLAYER_BIT = 48;
	localparam int MOVE_LSB   = 49;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ABSENT    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd4;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_PROBE,
		FSM_CHECK,
		FSM_EMIT
	} fsm_state_t;

	localparam logic [KEY_W-1:0] CELL_ROM [CELL_COUNT][16] = '{
		'{32'd0, 32'd1804289383, 32'd1505335290, 32'd1205554746, 32'd1968078301,
		  32'd590011675, 32'd290852541, 32'd1045618677, 32'd757547896, 32'd444454915,
		  32'd1215069295, 32'd1989311423, 32'd1687063760, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd1227918265, 32'd1995168598, 32'd623271449, 32'd319571911,
		  32'd1086411056, 32'd1857631170, 32'd1562469902, 32'd188364873, 32'd2017252061,
		  32'd1708421557, 32'd1416980517, 32'd1110582131, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd661315303, 32'd362860358, 32'd1126333064, 32'd818749156,
		  32'd514134199, 32'd1284681320, 32'd2055460636, 32'd1759697306, 32'd1439342445,
		  32'd71876166, 32'd842133572, 32'd1610048249, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd89789692, 32'd1920540202, 32'd1633333913, 32'd1322670498,
		  32'd2099602078, 32'd707676680, 32'd415587398, 32'd111714879, 32'd1956681178,
		  32'd1646153577, 32'd272081135, 32'd2115950905, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd598268513, 32'd286129175, 32'd1049489039, 32'd1834256778,
		  32'd1526261789, 32'd1224552512, 32'd912370068, 32'd608905406, 32'd296121872,
		  32'd2144173174, 32'd766615507, 32'd469800673, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd1096799004, 32'd1856146135, 32'd1557536497, 32'd183990277,
		  32'd2023096691, 32'd1714566222, 32'd351897519, 32'd38645617, 32'd1888747329,
		  32'd1582528011, 32'd1266305335, 32'd2049663803, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd1599854414, 32'd214780621, 32'd988039572, 32'd677741240,
		  32'd1455091466, 32'd81038786, 32'd839148289, 32'd537411375, 32'd1309058823,
		  32'd2085997689, 32'd707956661, 32'd1473834340, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd1019288695, 32'd1795081523, 32'd421093279, 32'd114810857,
		  32'd1954323550, 32'd1662292864, 32'd267189329, 32'd1049253433, 32'd1819267000,
		  32'd1503847010, 32'd128959393, 32'd1976973646, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd1530438140, 32'd158946141, 32'd1992573474, 32'd612787484,
		  32'd1396673875, 32'd1085856331, 32'd1854680614, 32'd479406137, 32'd171676246,
		  32'd938891628, 32'd640924275, 32'd331817660, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd2029893588, 32'd646125617, 32'd353272483, 32'd33267067,
		  32'd820885701, 32'd509160483, 32'd212803518, 32'd979730751, 32'd681628745,
		  32'd1443730104, 32'd1145702396, 32'd1907921120, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd383803757, 32'd1160721591, 32'd1920542938, 32'd543497852,
		  32'd1318701851, 32'd1012836014, 32'd708439997, 32'd405830208, 32'd101133139,
		  32'd872194726, 32'd574014618, 32'd252959875, 32'd0, 32'd0, 32'd0},
		'{32'd0, 32'd889299482, 32'd1654321064, 32'd283545993, 32'd1058850617,
		  32'd746974583, 32'd1511305073, 32'd1220372842, 32'd907127155, 32'd594260387,
		  32'd1372829053, 32'd2140627706, 32'd772686469, 32'd0, 32'd0, 32'd0}
	};

	localparam logic [KEY_W-1:0] MOVE_ROM [16] = '{
		32'd0, 32'd462648444, 32'd965671178, 32'd1468590567, 32'd901501096,
		32'd1396130115, 32'd829939201, 32'd255697463, 32'd755944791, 32'd178959410,
		32'd691212257, 32'd119126546, 32'd631979362, 32'd0, 32'd0, 32'd0
	};

	localparam logic [KEY_W-1:0] SIDE_ROM [2] = '{32'd842357681, 32'd1505898414};

endpackage

[hdl/zobtt_req_if.sv]
interface zobtt_req_if
	import zobtt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [BOARD_W-1:0] board;

	modport source (output valid, output mode, output board, input ready);
	modport sink (input valid, input mode, input board, output ready);
endinterface

[hdl/zobtt_rsp_if.sv]
interface zobtt_rsp_if
	import zobtt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  value;
	logic [SLOT_W-1:0]   slot_index;

	modport source (output valid, output status, output value, output slot_index, input ready);
	modport sink (input valid, input status, input value, input slot_index, output ready);
endinterface

[hdl/zobtt_hash.sv]
module zobtt_hash
	import zobtt_pkg::*;
(
	input  logic [BOARD_W-1:0] board,
	output logic [KEY_W-1:0]   key
);

	always_comb begin
		logic [KEY_W-1:0] acc;
		acc = SIDE_ROM[board[PLAYER_BIT]] ^ MOVE_ROM[board[MOVE_LSB +: CODE_W]];
		for (int i = 0; i < CELL_COUNT; i++) begin
			acc = acc ^ CELL_ROM[i][board[CODE_W*i +: CODE_W]];
		end
		key = acc;
	end

endmodule

[hdl/zobtt_ram.sv]
module zobtt_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/zobrist_transposition_table.sv]
// Zobrist-hashed transposition table.
// req channel (sink): mode (0 lookup, 1 insert or update) and a 64-bit board word.
// rsp channel (source): status, value and slot_index, one response per request.
// The key is hashed as the request is taken; the table is then probed one slot per
// cycle, the key shifting right by one after each occupied, non-matching slot.
// When the first probe ends a request, the block reads the entry, checks it and
// registers the response (read, check, respond); each further probe adds one read and
// check. The next request is accepted only after the response is registered: the entry
// memory has a single read port with a registered output, and one request is in flight
// at a time. After reset the block writes zero to every entry, one per cycle, and
// holds req.ready low until that pass ends.
// A response sits in an output register until taken; a new request is accepted
// meanwhile, and its response waits in the block while rsp.ready stays low.
module zobrist_transposition_table
	import zobtt_pkg::*;
#(
	parameter int TABLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	zobtt_req_if.sink   req,
	zobtt_rsp_if.source rsp
);

	localparam logic [KEY_W-1:0] IDX_MASK =
		KEY_W'((64'd1 << TABLE_BITS) - 64'd1);
	localparam logic [TABLE_BITS-1:0] CLR_LAST = '1;

	fsm_state_t state_q, state_d;

	logic [TABLE_BITS-1:0] clr_q;
	logic [KEY_W-1:0]      key_q;
	logic [KEY_W-1:0]      hash_key;
	logic [KEY_W-1:0]      key_nxt;
	logic                  mode_q;
	logic [BOARD_W-1:0]    board_q;

	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [VALUE_W-1:0]  res_value_q, res_value_d;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [KEY_W-1:0]    idx_full;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic [SLOT_W-1:0]   rsp_slot_q;

	logic                  req_ready;
	logic                  mem_we;
	logic [TABLE_BITS-1:0] mem_waddr;
	logic [BOARD_W-1:0]    mem_wdata;
	logic                  mem_re;
	logic [TABLE_BITS-1:0] mem_raddr;
	logic [BOARD_W-1:0]    mem_rdata;
	logic                  probe_done;
	logic                  key_shift;
	logic                  emit;
	logic                  hit;
	logic                  empty;

	zobtt_hash u_hash (
		.board (req.board),
		.key   (hash_key)
	);

	zobtt_ram #(
		.ADDR_W (TABLE_BITS),
		.DATA_W (BOARD_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign key_nxt  = key_q >> 1;
	assign idx_full = key_q & IDX_MASK;
	assign hit      = mem_rdata[MATCH_W-1:0] == board_q[MATCH_W-1:0];
	assign empty    = mem_rdata == '0;

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = key_q[TABLE_BITS-1:0];
		mem_wdata    = board_q;
		mem_re       = 1'b0;
		mem_raddr    = key_q[TABLE_BITS-1:0];
		probe_done   = 1'b0;
		key_shift    = 1'b0;
		emit         = 1'b0;
		res_status_d = STAT_ABSENT;
		res_value_d  = '0;
		case (state_q)
			FSM_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = FSM_PROBE;
				end
			end
			FSM_PROBE: begin
				mem_re  = 1'b1;
				state_d = FSM_CHECK;
			end
			FSM_CHECK: begin
				if (hit) begin
					probe_done = 1'b1;
					if (mode_q == MODE_INSERT) begin
						mem_we       = 1'b1;
						mem_wdata    = {board_q[BOARD_W-1:VALUE_LSB], mem_rdata[VALUE_LSB-1:0]};
						res_status_d = STAT_UPDATED;
					end else begin
						res_status_d = STAT_FOUND;
						res_value_d  = mem_rdata[VALUE_LSB +: VALUE_W];
					end
				end else if (empty) begin
					probe_done = 1'b1;
					if (mode_q == MODE_INSERT) begin
						mem_we       = 1'b1;
						res_status_d = STAT_INSERTED;
					end else begin
						res_status_d = STAT_ABSENT;
					end
				end else if (key_q == '0) begin
					probe_done   = 1'b1;
					res_status_d = STAT_EXHAUSTED;
				end else begin
					key_shift = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = key_nxt[TABLE_BITS-1:0];
				end
				if (probe_done) begin
					state_d = FSM_EMIT;
				end
			end
			FSM_EMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					emit    = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			key_q   <= hash_key;
			mode_q  <= req.mode;
			board_q <= req.board;
		end else if (key_shift) begin
			key_q <= key_nxt;
		end
		if (probe_done) begin
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
			res_slot_q   <= idx_full[SLOT_W-1:0];
		end
		if (emit) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
			rsp_slot_q   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req.ready      = req_ready;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.value      = rsp_value_q;
	assign rsp.slot_index = rsp_slot_q;

`ifndef NO_ASSERTIONS
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_CLEAR |-> !req.ready)
		else $error("request taken during clearing pass");

	a_accept_probes: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == FSM_PROBE)
		else $error("accepted request did not start a probe");

	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == FSM_CHECK |-> mode_q == MODE_INSERT)
		else $error("lookup wrote the table");

	a_exhausted_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_EXHAUSTED |-> rsp.slot_index == '0)
		else $error("exhausted probe ended off slot zero");

	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_FOUND |-> rsp.value == '0)
		else $error("value reported without a hit");
`endif

endmodule

[sim/tb_zobrist_transposition_table.sv]
module tb_zobrist_transposition_table
	import zobtt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_BITS = 16;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [31:0] IDX_MASK = 32'((64'd1 << TABLE_BITS) - 1);
	localparam logic [BOARD_W-1:0] MATCH_MASK = (64'd1 << MATCH_W) - 1;
	localparam logic [BOARD_W-1:0] VALUE_MASK = 64'hF << VALUE_LSB;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
		logic [SLOT_W-1:0]   slot_index;
	} reply_t;

	class tt_shadow;
		bit [BOARD_W-1:0] shadow_slots [int unsigned];
		reply_t           pending_replies [$];
		int               mismatches = 0;

		function logic [KEY_W-1:0] zobrist_key(logic [BOARD_W-1:0] b);
			logic [KEY_W-1:0] key;
			int i;
			key = '0;
			for (i = 0; i < CELL_COUNT; i++)
				key ^= CELL_ROM[i][b[CODE_W*i +: CODE_W]];
			key ^= SIDE_ROM[b[PLAYER_BIT]];
			key ^= MOVE_ROM[b[MOVE_LSB +: CODE_W]];
			return key;
		endfunction

		function reply_t note_request(logic m, logic [BOARD_W-1:0] b);
			logic [KEY_W-1:0]   key;
			logic [BOARD_W-1:0] word;
			logic [31:0]        idx;
			reply_t             r;
			int                 step;
			key = zobrist_key(b);
			r = '0;
			r.status = STAT_EXHAUSTED;
			for (step = 0; step <= KEY_W; step++) begin
				idx = key & IDX_MASK;
				r.slot_index = idx[SLOT_W-1:0];
				word = shadow_slots.exists(idx) ? shadow_slots[idx] : '0;
				if ((word & MATCH_MASK) == (b & MATCH_MASK)) begin
					if (m == MODE_INSERT) begin
						shadow_slots[idx] = (word & ~VALUE_MASK) | (b & VALUE_MASK);
						r.status = STAT_UPDATED;
					end else begin
						r.status = STAT_FOUND;
						r.value = word[VALUE_LSB +: VALUE_W];
					end
					break;
				end
				if (word == '0) begin
					if (m == MODE_INSERT) begin
						shadow_slots[idx] = b;
						r.status = STAT_INSERTED;
					end else begin
						r.status = STAT_ABSENT;
					end
					break;
				end
				if (key == '0) begin
					r.status = STAT_EXHAUSTED;
					r.slot_index = '0;
					break;
				end
				key = key >> 1;
			end
			pending_replies = {pending_replies, r};
			return r;
		endfunction

		task report(string what, longint got, longint want);
			$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_reply(logic [STATUS_W-1:0] s, logic [VALUE_W-1:0] v, logic [SLOT_W-1:0] si);
			reply_t w;
			if (pending_replies.size() == 0) begin
				report("reply with no request pending", s, 0);
				return;
			end
			w = pending_replies.pop_front();
			if (s !== w.status)
				report("status", s, w.status);
			if (v !== w.value)
				report("value", v, w.value);
			if (si !== w.slot_index)
				report("slot_index", si, w.slot_index);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   accepted = 0;
	logic [BOARD_W-1:0] stored_boards [$];
	tt_shadow shadow = new();

	zobtt_req_if req();
	zobtt_rsp_if rsp();

	zobrist_transposition_table #(.TABLE_BITS(TABLE_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rsp.ready <= 1'b0;
			end else if (rsp.ready && !calm && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(0, 2);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			shadow.check_reply(rsp.status, rsp.value, rsp.slot_index);

	function automatic bit is_blank(logic [CODE_W-1:0] c);
		return c == 4'd0 || c >= 4'd13;
	endfunction

	function automatic logic [CODE_W-1:0] blank_code();
		return ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
	endfunction

	// swap codes that hash to zero: same key, different position
	function automatic logic [BOARD_W-1:0] reshuffle_blanks(logic [BOARD_W-1:0] b);
		logic [BOARD_W-1:0] r;
		int i;
		r = b;
		for (i = 0; i < CELL_COUNT; i++)
			if (is_blank(r[CODE_W*i +: CODE_W]))
				r[CODE_W*i +: CODE_W] = blank_code();
		if (is_blank(r[MOVE_LSB +: CODE_W]))
			r[MOVE_LSB +: CODE_W] = blank_code();
		return r;
	endfunction

	task automatic send(input logic m, input logic [BOARD_W-1:0] b, output reply_t r);
		@(negedge clk);
		req.valid <= 1'b1;
		req.mode  <= m;
		req.board <= b;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		r = shadow.note_request(m, b);
		accepted++;
		if (m == MODE_INSERT && (r.status == STAT_INSERTED || r.status == STAT_UPDATED))
			stored_boards = {stored_boards, b};
		if (!calm && $urandom_range(0, 9) < 3) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		req.valid <= 1'b0;
		while (shadow.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// fill one probe chain with same-key positions until the probe runs out
	task automatic flood_chain();
		logic [BOARD_W-1:0] base;
		logic [BOARD_W-1:0] b;
		reply_t r;
		int i;
		base = {$urandom, $urandom};
		for (i = 0; i < CELL_COUNT; i++)
			base[CODE_W*i +: CODE_W] = ($urandom_range(0, 3) == 0) ?
				4'($urandom_range(1, 12)) : blank_code();
		base[MOVE_LSB +: CODE_W] = blank_code();
		for (i = 0; i < 48; i++) begin
			b = reshuffle_blanks(base);
			b[BOARD_W-1:MATCH_W] = 11'($urandom);
			send(MODE_INSERT, b, r);
			if (r.status == STAT_EXHAUSTED)
				break;
		end
		send(MODE_LOOKUP, reshuffle_blanks(base), r);
	endtask

	initial begin
		reply_t r;
		logic [BOARD_W-1:0] b0;
		logic [BOARD_W-1:0] b;
		int op;
		int start;
		bit second_flood;
		req.valid = 1'b0;
		req.mode  = MODE_LOOKUP;
		req.board = '0;
		arst_n    = 1'b0;
		second_flood = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		b0 = {$urandom, $urandom};
		b0[CODE_W-1:0] = 4'd0;
		b0[MOVE_LSB +: CODE_W] = 4'd0;
		send(MODE_LOOKUP, b0, r);
		send(MODE_INSERT, b0, r);
		b = b0;
		b[BOARD_W-1:MATCH_W] = ~b0[BOARD_W-1:MATCH_W];
		send(MODE_LOOKUP, b, r);
		b[BOARD_W-1:MATCH_W] = '1;
		send(MODE_INSERT, b, r);
		send(MODE_LOOKUP, b0, r);
		b[BOARD_W-1:MATCH_W] = '0;
		send(MODE_INSERT, b, r);
		send(MODE_LOOKUP, b0, r);
		b = b0;
		b[CODE_W-1:0] = 4'd13;
		send(MODE_INSERT, b, r);
		send(MODE_LOOKUP, b, r);
		b[CODE_W-1:0] = 4'd14;
		b[MOVE_LSB +: CODE_W] = 4'd15;
		send(MODE_LOOKUP, b, r);
		send(MODE_INSERT, b, r);
		send(MODE_LOOKUP, 64'd0, r);
		send(MODE_INSERT, {4'hA, 7'h55, 53'd0}, r);
		send(MODE_LOOKUP, 64'd0, r);
		send(MODE_INSERT, '1, r);
		send(MODE_LOOKUP, '1, r);
		b = {4'($urandom), 7'($urandom), 4'd12, 1'b0, {CELL_COUNT{4'd12}}};
		send(MODE_INSERT, b, r);
		send(MODE_LOOKUP, b, r);
		send(MODE_INSERT, 64'h001E_FFFF_FFFF_FFFF, r);
		send(MODE_LOOKUP, 64'h001E_FFFF_FFFF_FFFF, r);

		wait_for_replies();
		start = accepted;
		flood_chain();
		while (accepted < start + RANDOM_ITEMS) begin
			if (!second_flood && accepted >= start + 250) begin
				second_flood = 1'b1;
				wait_for_replies();
				flood_chain();
			end
			calm = (accepted >= start + RANDOM_ITEMS - 80);
			op = $urandom_range(0, 99);
			b = stored_boards[$urandom_range(0, stored_boards.size() - 1)];
			if (op < 25) begin
				send(MODE_INSERT, {$urandom, $urandom}, r);
			end else if (op < 45) begin
				b[BOARD_W-1:MATCH_W] = 11'($urandom);
				send(MODE_LOOKUP, b, r);
			end else if (op < 60) begin
				b[BOARD_W-1:MATCH_W] = 11'($urandom);
				send(MODE_INSERT, b, r);
			end else if (op < 75) begin
				send(MODE_LOOKUP, {$urandom, $urandom}, r);
			end else if (op < 85) begin
				send(1'($urandom), reshuffle_blanks(b), r);
			end else if (op < 90) begin
				send(1'($urandom), {11'($urandom), 53'd0}, r);
			end else begin
				send(1'($urandom), {$urandom, $urandom}, r);
			end
		end

		wait_for_replies();
		repeat (48) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/zobtt_pkg.sv
hdl/zobtt_req_if.sv
hdl/zobtt_rsp_if.sv
hdl/zobtt_hash.sv
hdl/zobtt_ram.sv
hdl/zobrist_transposition_table.sv
sim/tb_zobrist_transposition_table.sv
